### hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types, status codes and defaults for the sorted key store.
// ----------------------------------------------------------------------------
package sli_pkg;

	// Default number of key cells in the chain.
	localparam int unsigned CAPACITY = 16;

	// Widths fixed by the transaction fields.
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 5;

	typedef logic [STATUS_W-1:0] status_t;

	// Result status codes.
	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_DELETED  = 3'd1;
	localparam status_t ST_NOTFOUND = 3'd2;
	localparam status_t ST_EMPTY    = 3'd3;
	localparam status_t ST_FULL     = 3'd4;

	// Operation codes carried by the action field.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [KEY_W-1:0] key;
	} cell_ctl_t;

endpackage

### hw/rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// One slot of the chain: holds a key, compares it with the broadcast key and
// takes its new value from itself, the broadcast key or a neighbour.
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic                                 clk,
	input  sli_pkg::cell_ctl_t                   ctl,
	input  logic                                 occupied,
	input  logic                                 left_after,
	input  logic signed [sli_pkg::KEY_W-1:0]     left_key,
	input  logic signed [sli_pkg::KEY_W-1:0]     right_key,
	output logic signed [sli_pkg::KEY_W-1:0]     key,
	output logic signed [sli_pkg::KEY_W-1:0]     key_next,
	output logic                                 after,
	output logic                                 equal
);

	logic signed [sli_pkg::KEY_W-1:0] key_q;

	// A free slot counts as lying after the insertion point.
	assign after = !occupied || (key_q >= ctl.key);
	assign equal = occupied && (key_q == ctl.key);

	// Insert shifts the tail right by one; delete shifts it left by one.
	always_comb begin
		key_next = key_q;
		if (ctl.ins_en) begin
			if (left_after) begin
				key_next = left_key;
			end else if (after) begin
				key_next = ctl.key;
			end
		end else if (ctl.del_en) begin
			if (after) begin
				key_next = right_key;
			end
		end
	end

	// Key storage needs no reset: slots beyond the count are never read.
	always_ff @(posedge clk) begin
		key_q <= key_next;
	end

	assign key = key_q;

endmodule

### hw/rtl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Sorted list insert and delete
// Bounded ascending multiset of signed keys held in a chain of cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    action, key
// out      output     out_valid / out_ready  status, entry_count, smallest_key
//
// Every transaction is completed in the cycle it is accepted: all cells
// compare against the key at once and shift by one slot, so one transaction
// per cycle is sustained while the output is drained. The result appears in
// the cycle after acceptance in an output register; a new transaction is
// taken whenever that register is empty or being drained. Reset clears the
// count and the output valid flag; cell keys are not reset.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
	parameter int unsigned CAPACITY = sli_pkg::CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  logic signed [sli_pkg::KEY_W-1:0]     key,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sli_pkg::STATUS_W-1:0]         status,
	output logic [sli_pkg::COUNT_W-1:0]          entry_count,
	output logic signed [sli_pkg::KEY_W-1:0]     smallest_key
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 count_d;
	logic                             accept;
	logic                             full;
	logic                             found;
	sli_pkg::cell_ctl_t               ctl;
	sli_pkg::status_t                 status_d;
	logic [CAPACITY-1:0]              after_v;
	logic [CAPACITY-1:0]              equal_v;
	logic [CAPACITY-1:0]              occupied_v;
	logic signed [sli_pkg::KEY_W-1:0] cell_key  [CAPACITY];
	logic signed [sli_pkg::KEY_W-1:0] cell_next [CAPACITY];
	logic [CNT_W+sli_pkg::COUNT_W-1:0] count_ext;

	logic                             out_valid_q;
	sli_pkg::status_t                 status_q;
	logic [sli_pkg::COUNT_W-1:0]      entry_count_q;
	logic signed [sli_pkg::KEY_W-1:0] smallest_q;

	// Input is taken whenever the result register is free or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = |equal_v;

	// Command broadcast to the chain.
	always_comb begin
		ctl.key    = key;
		ctl.ins_en = accept && (action == sli_pkg::ACT_INSERT) && !full;
		ctl.del_en = accept && (action == sli_pkg::ACT_DELETE) && found;
	end

	// Chain of cells, each linked to the neighbours it has; an end cell uses its own key for a missing one.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occupied_v[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			if (CAPACITY > 1) begin : g_more
				sli_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.occupied   (occupied_v[i]),
					.left_after (1'b0),
					.left_key   (cell_key[i]),
					.right_key  (cell_key[i+1]),
					.key        (cell_key[i]),
					.key_next   (cell_next[i]),
					.after      (after_v[i]),
					.equal      (equal_v[i])
				);
			end else begin : g_only
				sli_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.occupied   (occupied_v[i]),
					.left_after (1'b0),
					.left_key   (cell_key[i]),
					.right_key  (cell_key[i]),
					.key        (cell_key[i]),
					.key_next   (cell_next[i]),
					.after      (after_v[i]),
					.equal      (equal_v[i])
				);
			end
		end else if (i == CAPACITY - 1) begin : g_last
			sli_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occupied   (occupied_v[i]),
				.left_after (after_v[i-1]),
				.left_key   (cell_key[i-1]),
				.right_key  (cell_key[i]),
				.key        (cell_key[i]),
				.key_next   (cell_next[i]),
				.after      (after_v[i]),
				.equal      (equal_v[i])
			);
		end else begin : g_mid
			sli_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occupied   (occupied_v[i]),
				.left_after (after_v[i-1]),
				.left_key   (cell_key[i-1]),
				.right_key  (cell_key[i+1]),
				.key        (cell_key[i]),
				.key_next   (cell_next[i]),
				.after      (after_v[i]),
				.equal      (equal_v[i])
			);
		end
	end

	// Status and next count for the transaction being accepted.
	always_comb begin
		count_d = count_q;
		if (action == sli_pkg::ACT_INSERT) begin
			if (full) begin
				status_d = sli_pkg::ST_FULL;
			end else begin
				status_d = sli_pkg::ST_INSERTED;
				count_d  = count_q + 1'b1;
			end
		end else if (count_q == '0) begin
			status_d = sli_pkg::ST_EMPTY;
		end else if (found) begin
			status_d = sli_pkg::ST_DELETED;
			count_d  = count_q - 1'b1;
		end else begin
			status_d = sli_pkg::ST_NOTFOUND;
		end
	end

	// The reported count keeps only its low bits.
	assign count_ext = {{sli_pkg::COUNT_W{1'b0}}, count_d};

	// Count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			entry_count_q <= count_ext[sli_pkg::COUNT_W-1:0];
			smallest_q    <= (count_d != '0) ? cell_next[0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
	assign smallest_key = smallest_q;

endmodule
